### hw/rtl/dltq_pkg.sv
// Package for the delta-list timer queue.
// Request kinds, result codes, sequencer states and the slot store command.
// No dependencies.
package dltq_pkg;

    localparam logic [1:0] K_SET   = 2'd0;
    localparam logic [1:0] K_CLEAR = 2'd1;
    localparam logic [1:0] K_ADV   = 2'd2;
    localparam logic [1:0] K_ALL   = 2'd3;

    localparam logic [2:0] EV_SET_OK  = 3'd0;
    localparam logic [2:0] EV_FULL    = 3'd1;
    localparam logic [2:0] EV_CLEARED = 3'd2;
    localparam logic [2:0] EV_MISSING = 3'd3;
    localparam logic [2:0] EV_EXPIRED = 3'd4;
    localparam logic [2:0] EV_ALL_CLR = 3'd5;
    localparam logic [2:0] EV_ADV_END = 3'd6;

    localparam logic [31:0] EMPTY_HEAD_DELAY = 32'd1000000;
    localparam logic [5:0]  MAX_EXPIRIES     = 6'd63;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_INS  = 6'b000100,
        S_FIND = 6'b001000,
        S_ADV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic        ins;
        logic        split;
        logic        drp;
        logic        fold;
        logic        wr;
        logic [31:0] dly;
        logic [31:0] aux;
        logic [31:0] id;
        logic [31:0] per;
        logic [15:0] tag;
    } t_slot_cmd;

endpackage

### hw/rtl/dltq_slots.sv
// Sorted timer slot store: insert with shift up, drop with shift down,
// single delay write, reads at a position. Depends on dltq_pkg.
module dltq_slots
    import dltq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_slot_cmd                     i_cmd,
    input  logic [$clog2(MAX_TIMERS)-1:0] i_pos,
    output logic [31:0]                   o_dly,
    output logic [31:0]                   o_nxt_dly,
    output logic [31:0]                   o_id,
    output logic [31:0]                   o_per,
    output logic [15:0]                   o_tag,
    output logic [31:0]                   o_head_dly
);

    localparam int IW = $clog2(MAX_TIMERS);

    logic [31:0] r_dly [MAX_TIMERS];
    logic [31:0] r_id  [MAX_TIMERS];
    logic [31:0] r_per [MAX_TIMERS];
    logic [15:0] r_tag [MAX_TIMERS];
    logic [IW-1:0] nxt_pos;

    assign nxt_pos    = (int'(i_pos) == MAX_TIMERS - 1) ? i_pos : i_pos + 1'b1;
    assign o_dly      = r_dly[i_pos];
    assign o_nxt_dly  = r_dly[nxt_pos];
    assign o_id       = r_id[i_pos];
    assign o_per      = r_per[i_pos];
    assign o_tag      = r_tag[i_pos];
    assign o_head_dly = r_dly[0];

    // no reset: entries are read only below the fill count
    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            for (int i = 0; i < MAX_TIMERS; i++) begin
                if (i_cmd.ins) begin
                    if (i > int'(i_pos)) begin
                        r_dly[i] <= (i_cmd.split && i == int'(i_pos) + 1) ? i_cmd.aux
                                                                           : r_dly[i-1];
                        r_id[i]  <= r_id[i-1];
                        r_per[i] <= r_per[i-1];
                        r_tag[i] <= r_tag[i-1];
                    end else if (i == int'(i_pos)) begin
                        r_dly[i] <= i_cmd.dly;
                        r_id[i]  <= i_cmd.id;
                        r_per[i] <= i_cmd.per;
                        r_tag[i] <= i_cmd.tag;
                    end
                end else if (i_cmd.drp) begin
                    if (i >= int'(i_pos) && i < MAX_TIMERS - 1) begin
                        r_dly[i] <= (i_cmd.fold && i == int'(i_pos)) ? i_cmd.aux
                                                                     : r_dly[i+1];
                        r_id[i]  <= r_id[i+1];
                        r_per[i] <= r_per[i+1];
                        r_tag[i] <= r_tag[i+1];
                    end
                end else if (i_cmd.wr && i == int'(i_pos)) begin
                    r_dly[i] <= i_cmd.dly;
                end
            end
        end
    end

endmodule

### hw/rtl/delta_list_timer_queue_top.sv
// Delta-list timer queue top: request sequencer, shared subtract/compare
// unit and result register. Depends on dltq_pkg and dltq_slots.
//
//  channel   handshake           payload
//  request   i_valid / o_ready   i_kind i_now i_delay i_periodic i_callback_tag i_target_id
//  result    o_valid / i_ready   o_event_res o_timer_tag_id o_expired_tag o_was_periodic
//                                o_pending o_head_delay o_base_stamp o_last
//
// One request at a time; o_ready is high only in idle.
// Set: a walk over up to occupancy slots, then an insert; clear: a search over up to occupancy slots.
// Advance: one head check per step, plus a re-insert walk per periodic expiry.
// Each result waits in the output register until taken; no other work meanwhile.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module delta_list_timer_queue_top
    import dltq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now,
    input  logic [31:0] i_delay,
    input  logic        i_periodic,
    input  logic [15:0] i_callback_tag,
    input  logic [31:0] i_target_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_timer_tag_id,
    output logic [15:0] o_expired_tag,
    output logic        o_was_periodic,
    output logic        o_pending,
    output logic [31:0] o_head_delay,
    output logic [31:0] o_base_stamp,
    output logic        o_last
);

    localparam int IW = $clog2(MAX_TIMERS);
    localparam int OW = $clog2(MAX_TIMERS + 1);
    localparam logic [OW-1:0] FULL = OW'(MAX_TIMERS);

    t_state      r_st;
    logic [OW-1:0] r_occ, r_pos;
    logic [31:0] r_idc, r_base, r_t, r_el, r_tgt;
    logic [31:0] r_nid, r_nper;
    logic [15:0] r_ntag;
    logic        r_reins;
    logic [5:0]  r_fired;
    logic [2:0]  r_ev;
    logic [31:0] r_oid;
    logic [15:0] r_otag;
    logic        r_oper, r_last;

    t_slot_cmd   cmd;
    logic [31:0] rd_dly, rd_nxt, rd_id, rd_per, head_dly;
    logic [15:0] rd_tag;
    logic [31:0] op_a, diff_ab, diff_ba;
    logic        lt, in_list;

    dltq_slots #(.MAX_TIMERS(MAX_TIMERS)) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_pos      (r_pos[IW-1:0]),
        .o_dly      (rd_dly),
        .o_nxt_dly  (rd_nxt),
        .o_id       (rd_id),
        .o_per      (rd_per),
        .o_tag      (rd_tag),
        .o_head_dly (head_dly)
    );

    // shared subtract/compare unit
    assign op_a    = (r_st == S_ADV) ? r_el : r_t;
    assign lt      = op_a < rd_dly;
    assign diff_ab = op_a - rd_dly;
    assign diff_ba = rd_dly - op_a;
    assign in_list = r_pos < r_occ;

    always_comb begin
        cmd = '0;
        cmd.id  = r_nid;
        cmd.per = r_nper;
        cmd.tag = r_ntag;
        case (r_st)
            S_INS: begin
                cmd.ins   = 1'b1;
                cmd.dly   = r_t;
                cmd.split = in_list;
                cmd.aux   = diff_ba;
            end
            S_FIND: begin
                if (in_list && rd_id == r_tgt) begin
                    cmd.drp  = 1'b1;
                    cmd.fold = (r_pos + 1'b1) < r_occ;
                    cmd.aux  = rd_dly + rd_nxt;
                end
            end
            S_ADV: begin
                if (r_occ != '0 && r_fired != MAX_EXPIRIES) begin
                    if (lt) begin
                        cmd.wr  = 1'b1;
                        cmd.dly = diff_ba;
                    end else begin
                        cmd.drp = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_occ   <= '0;
            r_idc   <= '0;
            r_base  <= '0;
            r_pos   <= '0;
            r_fired <= '0;
            r_reins <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pos   <= '0;
                        r_oid   <= '0;
                        r_otag  <= '0;
                        r_oper  <= 1'b0;
                        r_last  <= i_kind != K_ADV;
                        r_reins <= 1'b0;
                        case (i_kind)
                            K_SET: begin
                                if (r_occ >= FULL) begin
                                    r_ev <= EV_FULL;
                                    r_st <= S_OUT;
                                end else begin
                                    r_idc  <= r_idc + 32'd1;
                                    r_nid  <= r_idc + 32'd1;
                                    r_nper <= i_periodic ? i_delay : 32'd0;
                                    r_ntag <= i_callback_tag;
                                    if (r_occ == '0) begin
                                        r_base <= i_now;
                                        r_t    <= i_delay;
                                    end else begin
                                        r_t <= i_delay + (i_now - r_base);
                                    end
                                    r_st <= S_WALK;
                                end
                            end
                            K_CLEAR: begin
                                r_tgt <= i_target_id;
                                r_st  <= S_FIND;
                            end
                            K_ADV: begin
                                r_el    <= i_now - r_base;
                                r_base  <= i_now;
                                r_fired <= '0;
                                r_st    <= S_ADV;
                            end
                            default: begin
                                r_occ <= '0;
                                r_ev  <= EV_ALL_CLR;
                                r_st  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (in_list && !lt) begin
                        r_t   <= diff_ab;
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_st <= S_INS;
                    end
                end
                S_INS: begin
                    r_occ <= r_occ + 1'b1;
                    if (r_reins) begin
                        r_ev   <= EV_EXPIRED;
                        r_oid  <= r_nid;
                        r_otag <= r_ntag;
                        r_oper <= 1'b1;
                    end else begin
                        r_ev  <= EV_SET_OK;
                        r_oid <= r_nid;
                    end
                    r_st <= S_OUT;
                end
                S_FIND: begin
                    r_oid <= r_tgt;
                    if (!in_list) begin
                        r_ev <= EV_MISSING;
                        r_st <= S_OUT;
                    end else if (rd_id == r_tgt) begin
                        r_occ <= r_occ - 1'b1;
                        r_ev  <= EV_CLEARED;
                        r_st  <= S_OUT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_ADV: begin
                    if (r_occ == '0 || r_fired == MAX_EXPIRIES || lt) begin
                        r_ev   <= EV_ADV_END;
                        r_oid  <= '0;
                        r_otag <= '0;
                        r_oper <= 1'b0;
                        r_last <= 1'b1;
                        r_st   <= S_OUT;
                    end else begin
                        r_el    <= diff_ab;
                        r_occ   <= r_occ - 1'b1;
                        r_fired <= r_fired + 6'd1;
                        r_nid   <= rd_id;
                        r_nper  <= rd_per;
                        r_ntag  <= rd_tag;
                        if (rd_per != '0) begin
                            r_t     <= rd_per;
                            r_reins <= 1'b1;
                            r_st    <= S_WALK;
                        end else begin
                            r_ev   <= EV_EXPIRED;
                            r_oid  <= rd_id;
                            r_otag <= rd_tag;
                            r_oper <= 1'b0;
                            r_st   <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_pos   <= '0;
                        r_reins <= 1'b0;
                        r_st    <= r_last ? S_IDLE : S_ADV;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = r_st == S_IDLE;
    assign o_valid        = r_st == S_OUT;
    assign o_event_res    = r_ev;
    assign o_timer_tag_id = r_oid;
    assign o_expired_tag  = r_otag;
    assign o_was_periodic = r_oper;
    assign o_last         = r_last;
    assign o_pending      = r_occ != '0;
    assign o_head_delay   = (r_occ != '0) ? head_dly : EMPTY_HEAD_DELAY;
    assign o_base_stamp   = r_base;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL) else $error("occupancy above capacity");

    a_fired_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && r_ev == EV_EXPIRED) |-> (r_fired != '0 && !r_last))
        else $error("expiry result outside advance");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && r_ev == EV_FULL) |-> (r_occ == FULL && r_last))
        else $error("queue full reported with room");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_occ) && $stable(r_base)))
        else $error("state moved while result stalled");

endmodule

### sim/dltq_checker.sv
// Checker for the delta-list timer queue: watches request and result channels,
// predicts every result of each accepted request and compares field by field.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
module dltq_checker
    import dltq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now,
    input  logic [31:0] i_delay,
    input  logic        i_periodic,
    input  logic [15:0] i_callback_tag,
    input  logic [31:0] i_target_id,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_event_res,
    input  logic [31:0] i_timer_tag_id,
    input  logic [15:0] i_expired_tag,
    input  logic        i_was_periodic,
    input  logic        i_pending,
    input  logic [31:0] i_head_delay,
    input  logic [31:0] i_base_stamp,
    input  logic        i_last,
    output int          o_errors,
    output int          o_outstanding,
    output int          o_results,
    output int          o_expiries
);

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] id;
        logic [15:0] tag;
        logic        per;
        logic        pend;
        logic [31:0] head;
        logic [31:0] base;
        logic        last;
    } t_result;

    logic [31:0] q_dly [MAX_TIMERS];
    logic [31:0] q_id  [MAX_TIMERS];
    logic [31:0] q_per [MAX_TIMERS];
    logic [15:0] q_tag [MAX_TIMERS];
    int          q_cnt;
    logic [31:0] id_ctr;
    logic [31:0] base_t;
    t_result     expected_results[$];

    function automatic void insert_timer(logic [31:0] t, logic [31:0] id,
                                         logic [31:0] per, logic [15:0] tag);
        int pos;
        pos = 0;
        while (pos < q_cnt) begin
            if (t < q_dly[pos]) begin
                q_dly[pos] = q_dly[pos] - t;
                break;
            end
            t = t - q_dly[pos];
            pos++;
        end
        for (int i = q_cnt; i > pos; i--) begin
            q_dly[i] = q_dly[i-1];
            q_id[i]  = q_id[i-1];
            q_per[i] = q_per[i-1];
            q_tag[i] = q_tag[i-1];
        end
        q_dly[pos] = t;
        q_id[pos]  = id;
        q_per[pos] = per;
        q_tag[pos] = tag;
        q_cnt++;
    endfunction

    function automatic void remove_timer(int pos);
        for (int i = pos; i < q_cnt - 1; i++) begin
            q_dly[i] = q_dly[i+1];
            q_id[i]  = q_id[i+1];
            q_per[i] = q_per[i+1];
            q_tag[i] = q_tag[i+1];
        end
        q_cnt--;
    endfunction

    function automatic void push_result(logic [2:0] ev, logic [31:0] id,
                                        logic [15:0] tag, logic per);
        t_result r;
        r.ev   = ev;
        r.id   = id;
        r.tag  = tag;
        r.per  = per;
        r.pend = (q_cnt > 0);
        r.head = (q_cnt > 0) ? q_dly[0] : EMPTY_HEAD_DELAY;
        r.base = base_t;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request();
        logic [31:0] t;
        logic [31:0] elapsed;
        logic [31:0] id;
        logic [31:0] per;
        logic [15:0] tag;
        int          pos;
        int          fired;
        t_result     r;
        case (i_kind)
            K_SET: begin
                if (q_cnt >= MAX_TIMERS) begin
                    push_result(EV_FULL, '0, '0, 1'b0);
                end else begin
                    t = i_delay;
                    id_ctr = id_ctr + 1;
                    if (q_cnt == 0) base_t = i_now;
                    else t = t + (i_now - base_t);
                    insert_timer(t, id_ctr, i_periodic ? i_delay : '0, i_callback_tag);
                    push_result(EV_SET_OK, id_ctr, '0, 1'b0);
                end
            end
            K_CLEAR: begin
                pos = 0;
                while (pos < q_cnt && q_id[pos] != i_target_id) pos++;
                if (pos < q_cnt) begin
                    if (pos + 1 < q_cnt) q_dly[pos+1] = q_dly[pos+1] + q_dly[pos];
                    remove_timer(pos);
                    push_result(EV_CLEARED, i_target_id, '0, 1'b0);
                end else begin
                    push_result(EV_MISSING, i_target_id, '0, 1'b0);
                end
            end
            K_ADV: begin
                elapsed = i_now - base_t;
                base_t = i_now;
                fired = 0;
                while (q_cnt > 0 && fired < MAX_EXPIRIES) begin
                    if (q_dly[0] > elapsed) begin
                        q_dly[0] = q_dly[0] - elapsed;
                        break;
                    end
                    elapsed = elapsed - q_dly[0];
                    id  = q_id[0];
                    per = q_per[0];
                    tag = q_tag[0];
                    remove_timer(0);
                    if (per != 0) insert_timer(per, id, per, tag);
                    push_result(EV_EXPIRED, id, tag, per != 0);
                    fired++;
                end
                push_result(EV_ADV_END, '0, '0, 1'b0);
            end
            default: begin
                q_cnt = 0;
                push_result(EV_ALL_CLR, '0, '0, 1'b0);
            end
        endcase
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    always_ff @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            q_cnt  = 0;
            id_ctr = '0;
            base_t = '0;
            expected_results.delete();
            o_errors   <= 0;
            o_results  <= 0;
            o_expiries <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_results <= o_results + 1;
                if (i_event_res == EV_EXPIRED) o_expiries <= o_expiries + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result ev=%0d id=%0d", $time,
                             i_event_res, i_timer_tag_id);
                    o_errors <= o_errors + 1;
                end else begin
                    r = expected_results.pop_front();
                    if (r != {i_event_res, i_timer_tag_id, i_expired_tag, i_was_periodic,
                              i_pending, i_head_delay, i_base_stamp, i_last}) begin
                        $display("%0t: mismatch expected ev=%0d id=%0d tag=%0d per=%0d pend=%0d head=%0d base=%0d last=%0d",
                                 $time, r.ev, r.id, r.tag, r.per, r.pend, r.head, r.base, r.last);
                        $display("%0t:          actual ev=%0d id=%0d tag=%0d per=%0d pend=%0d head=%0d base=%0d last=%0d",
                                 $time, i_event_res, i_timer_tag_id, i_expired_tag, i_was_periodic,
                                 i_pending, i_head_delay, i_base_stamp, i_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_req_ready) predict_request();
        end
        o_outstanding <= expected_results.size();
    end

endmodule

### sim/delta_list_timer_queue_top_tb.sv
// Testbench top for the delta-list timer queue: drives directed and random
// requests with random gaps and result stalls, and reports the verdict.
// Depends on dltq_pkg, dltq_checker and delta_list_timer_queue_top.
`timescale 1ns / 1ps
module delta_list_timer_queue_top_tb;
    import dltq_pkg::*;

    localparam int MAX_TIMERS = 16;
    localparam int CYCLE_LIMIT = 10000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = K_SET;
    logic [31:0] i_now = '0;
    logic [31:0] i_delay = '0;
    logic        i_periodic = 1'b0;
    logic [15:0] i_callback_tag = '0;
    logic [31:0] i_target_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [31:0] o_timer_tag_id;
    logic [15:0] o_expired_tag;
    logic        o_was_periodic;
    logic        o_pending;
    logic [31:0] o_head_delay;
    logic [31:0] o_base_stamp;
    logic        o_last;

    int          errors;
    int          outstanding;
    int          results;
    int          expiries;
    int          cycles = 0;
    int          sent = 0;
    logic [31:0] clock_now = 32'd5000;
    logic [31:0] ids_given = '0;

    always #4 i_clk = ~i_clk;

    delta_list_timer_queue_top #(.MAX_TIMERS(MAX_TIMERS)) uut (.*);

    dltq_checker #(.MAX_TIMERS(MAX_TIMERS)) u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_req_ready(o_ready), .i_kind, .i_now, .i_delay,
        .i_periodic, .i_callback_tag, .i_target_id, .i_res_valid(o_valid),
        .i_res_ready(i_ready), .i_event_res(o_event_res), .i_timer_tag_id(o_timer_tag_id),
        .i_expired_tag(o_expired_tag), .i_was_periodic(o_was_periodic),
        .i_pending(o_pending), .i_head_delay(o_head_delay), .i_base_stamp(o_base_stamp),
        .i_last(o_last), .o_errors(errors), .o_outstanding(outstanding),
        .o_results(results), .o_expiries(expiries)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("delta_list_timer_queue_top test failed");
            $finish;
        end
    end

    // result side: random stalls, with calm stretches
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [31:0] now, logic [31:0] dly,
                                logic per, logic [15:0] tag, logic [31:0] target);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_now          <= now;
        i_delay        <= dly;
        i_periodic     <= per;
        i_callback_tag <= tag;
        i_target_id    <= target;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (kind == K_SET) ids_given = ids_given + 1;
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        int sel;
        logic [31:0] d;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_request(K_CLEAR, '0, '0, 1'b0, '0, 32'd7);
        send_request(K_ADV, 32'd100, '0, 1'b0, '0, '0);
        send_request(K_SET, 32'd200, 32'd0, 1'b1, 16'hFFFF, '0);
        send_request(K_SET, 32'd210, 32'd50, 1'b1, 16'h0000, '0);
        send_request(K_SET, 32'd220, 32'd40, 1'b0, 16'hA5A5, '0);
        send_request(K_SET, 32'd230, 32'hFFFF_FFFF, 1'b0, 16'h5A5A, '0);
        send_request(K_CLEAR, '0, '0, 1'b0, '0, 32'd3);
        send_request(K_CLEAR, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
        send_request(K_ADV, 32'd260, '0, 1'b0, '0, '0);
        send_request(K_ADV, 32'hFFFF_FFF0, '0, 1'b0, '0, '0);
        send_request(K_ALL, '0, '0, 1'b0, '0, '0);
        for (int i = 0; i < MAX_TIMERS + 1; i++)
            send_request(K_SET, 32'd1000, 32'd10, 1'b1, 16'(i), '0);
        // 16 repeating 10us timers: more than 63 expiries in one advance
        send_request(K_ADV, 32'd2000, '0, 1'b0, '0, '0);
        send_request(K_ALL, '0, '0, 1'b0, '0, '0);
        clock_now = 32'd2000;
        drain();

        for (int n = 0; n < 400; n++) begin
            if (n == 200) drain();
            sel = $urandom_range(0, 99);
            clock_now = clock_now + $urandom_range(0, 300);
            if (n % 97 == 50) clock_now = 32'hFFFF_FF00 + $urandom_range(0, 200);
            if (sel < 45) begin
                case ($urandom_range(0, 9))
                    0: d = $urandom();
                    1: d = 32'd0;
                    2: d = 32'hFFFF_FFFF;
                    default: d = $urandom_range(0, 600);
                endcase
                send_request(K_SET, clock_now, d, 1'($urandom_range(0, 1)),
                             16'($urandom()), $urandom());
            end else if (sel < 65) begin
                send_request(K_CLEAR, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                             16'($urandom()),
                             ($urandom_range(0, 7) == 0) ? $urandom()
                             : ids_given - $urandom_range(0, 20));
            end else if (sel < 97) begin
                send_request(K_ADV, clock_now, $urandom(), 1'($urandom_range(0, 1)),
                             16'($urandom()), $urandom());
            end else begin
                send_request(K_ALL, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                             16'($urandom()), $urandom());
            end
        end
        drain();

        $display("sent %0d requests, checked %0d results including %0d expiries",
                 sent, results, expiries);
        if (errors == 0) begin
            $display("delta_list_timer_queue_top test passed");
        end else begin
            $display("delta_list_timer_queue_top test failed");
        end
        $finish;
    end

endmodule

### delta_list_timer_queue_top.f
hw/rtl/dltq_pkg.sv
hw/rtl/dltq_slots.sv
hw/rtl/delta_list_timer_queue_top.sv
sim/dltq_checker.sv
sim/delta_list_timer_queue_top_tb.sv
